### sv/pidl_pkg.sv
`default_nettype none
package pidl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int Q_DEPTH_DEF = 2;
  localparam int POS_W = 8;
  localparam int DATA_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LIST = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic                     last;
  } out_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_LIST
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic                at_front;
    logic [POS_W-1:0]    skip;
    logic [DATA_W-1:0]   value;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_MOD,
    BK_INS_RD,
    BK_INS_WR,
    BK_DEL_RD0,
    BK_DEL_CAP,
    BK_DEL_RD,
    BK_DEL_WR,
    BK_LIST
  } bk_state_e;

endpackage
`default_nettype wire

### sv/pidl_front.sv
`default_nettype none
module pidl_front (
  input  wire logic          start,
  input  wire pidl_pkg::in_t in_data,
  input  wire logic          q_full,
  output logic               busy,
  output logic               push,
  output pidl_pkg::cmd_t     push_cmd
);
  import pidl_pkg::*;

  always_comb begin
    busy = q_full;
    push = 1'b0;
    push_cmd.op = OP_INSERT;
    push_cmd.at_front = (in_data.position == POS_W'(1));
    push_cmd.skip = (in_data.position >= POS_W'(2)) ? in_data.position - POS_W'(2) : '0;
    push_cmd.value = in_data.value;
    case (in_data.action)
      ACT_INSERT: begin
        push_cmd.op = OP_INSERT;
        push = start && !q_full;
      end
      ACT_DELETE: begin
        push_cmd.op = OP_DELETE;
        push = start && !q_full;
      end
      ACT_LIST: begin
        push_cmd.op = OP_LIST;
        push = start && !q_full;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/pidl_queue.sv
`default_nettype none
module pidl_queue #(
  parameter int QDEPTH = pidl_pkg::Q_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pidl_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output pidl_pkg::cmd_t      pop_cmd,
  output logic                empty
);
  import pidl_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic          do_push, do_pop;

  assign full = (num_r == NW'(QDEPTH));
  assign empty = (num_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    num_nxt = num_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      num_nxt = num_r + NW'(1);
    end else if (do_pop && !do_push) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      num_r <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### sv/pidl_back.sv
`default_nettype none
module pidl_back #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire pidl_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output pidl_pkg::out_t      out_data
);
  import pidl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int RW = CW + 1;
  localparam int BW = $clog2(POS_W);

  logic [DATA_W-1:0] mem [DEPTH];

  bk_state_e         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              pend_r, pend_nxt;
  logic              plast_r, plast_nxt;
  logic              out_valid_r;
  out_t              out_data_r;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data_r;
  logic              emit;
  out_t              emit_data;

  logic              is_empty, is_full, mod_done;
  logic [RW-1:0]     sh;
  logic [CW-1:0]     rem_new, rem_inc, del_idx;
  logic [CW-1:0]     p_inc;

  assign is_empty = (cnt_r == '0);
  assign is_full = (cnt_r == CW'(DEPTH));
  assign mod_done = (bit_r == '0);
  assign sh = {rem_r, cmd_r.skip[bit_r]};
  assign rem_new = (sh >= {1'b0, cnt_r}) ? CW'(sh - {1'b0, cnt_r}) : sh[CW-1:0];
  assign rem_inc = rem_new + CW'(1);
  assign del_idx = (rem_inc == cnt_r) ? '0 : rem_inc;
  assign p_inc = p_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        case (cmd_r.op)
          OP_INSERT: begin
            if (cmd_r.at_front) state_nxt = is_full ? BK_IDLE : BK_INS_RD;
            else if (is_empty || is_full) state_nxt = BK_IDLE;
            else state_nxt = BK_MOD;
          end
          OP_DELETE: begin
            if (is_empty) state_nxt = BK_IDLE;
            else if (cmd_r.at_front) state_nxt = BK_DEL_RD0;
            else state_nxt = BK_MOD;
          end
          OP_LIST: begin
            state_nxt = is_empty ? BK_IDLE : BK_LIST;
          end
          default: state_nxt = BK_IDLE;
        endcase
      end
      BK_MOD: begin
        if (mod_done) state_nxt = (cmd_r.op == OP_INSERT) ? BK_INS_RD : BK_DEL_RD0;
      end
      BK_INS_RD: state_nxt = (p_r == idx_r) ? BK_IDLE : BK_INS_WR;
      BK_INS_WR: state_nxt = BK_INS_RD;
      BK_DEL_RD0: state_nxt = BK_DEL_CAP;
      BK_DEL_CAP: state_nxt = BK_DEL_RD;
      BK_DEL_RD: state_nxt = (p_inc >= cnt_r) ? BK_IDLE : BK_DEL_WR;
      BK_DEL_WR: state_nxt = BK_DEL_RD;
      BK_LIST: begin
        if (pend_r && plast_r) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    cmd_nxt = cmd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    p_nxt = p_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    res_nxt = res_r;
    pend_nxt = 1'b0;
    plast_nxt = plast_r;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = cmd_r.value;
    rd_en = 1'b0;
    rd_addr = '0;
    emit = 1'b0;
    emit_data.data_out = '0;
    emit_data.status = ST_OK;
    emit_data.last = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
        end
      end
      BK_DECIDE: begin
        idx_nxt = '0;
        p_nxt = cnt_r;
        rem_nxt = '0;
        bit_nxt = BW'(POS_W - 1);
        case (cmd_r.op)
          OP_INSERT: begin
            if (is_full) begin
              emit = 1'b1;
              emit_data.status = ST_FULL;
            end else if (!cmd_r.at_front && is_empty) begin
              emit = 1'b1;
              emit_data.status = ST_EMPTY;
            end
          end
          OP_DELETE: begin
            if (is_empty) begin
              emit = 1'b1;
              emit_data.status = ST_EMPTY;
            end
          end
          OP_LIST: begin
            p_nxt = '0;
            if (is_empty) begin
              emit = 1'b1;
              emit_data.status = ST_EMPTY;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      BK_MOD: begin
        rem_nxt = rem_new;
        bit_nxt = bit_r - BW'(1);
        if (mod_done) begin
          idx_nxt = (cmd_r.op == OP_INSERT) ? rem_inc : del_idx;
        end
      end
      BK_INS_RD: begin
        if (p_r == idx_r) begin
          wr_en = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_data = cmd_r.value;
          cnt_nxt = cnt_r + CW'(1);
          emit = 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(p_r - CW'(1));
        end
      end
      BK_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = p_r[AW-1:0];
        wr_data = rd_data_r;
        p_nxt = p_r - CW'(1);
      end
      BK_DEL_RD0: begin
        rd_en = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      BK_DEL_CAP: begin
        res_nxt = rd_data_r;
        p_nxt = idx_r;
      end
      BK_DEL_RD: begin
        if (p_inc >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          emit = 1'b1;
          emit_data.data_out = res_r;
        end else begin
          rd_en = 1'b1;
          rd_addr = p_inc[AW-1:0];
        end
      end
      BK_DEL_WR: begin
        wr_en = 1'b1;
        wr_addr = p_r[AW-1:0];
        wr_data = rd_data_r;
        p_nxt = p_inc;
      end
      BK_LIST: begin
        if (p_r != cnt_r) begin
          rd_en = 1'b1;
          rd_addr = p_r[AW-1:0];
          p_nxt = p_inc;
          pend_nxt = 1'b1;
          plast_nxt = (p_inc == cnt_r);
        end
        if (pend_r) begin
          emit = 1'b1;
          emit_data.data_out = rd_data_r;
          emit_data.last = plast_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    p_r <= p_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
    plast_r <= plast_nxt;
    out_data_r <= emit_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> (state_r == BK_IDLE && emit == 1'b0))
    else $error("count changed outside transaction end");

  a_list_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_LIST |-> !wr_en)
    else $error("memory write during list");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_MOD |-> rem_r < cnt_r)
    else $error("remainder out of range");

endmodule
`default_nettype wire

### sv/positional_insert_delete_list_unit.sv
// Insert and delete away from the front first reduce the position modulo the element count,
// then move elements one at a time by a read and a write; list reads one element per
// cycle after the first read. The back end works on one transaction at a time, and later
// commands wait in the command queue until it is done. Results are strobed on out_valid
// for one cycle; the receiver cannot stall. Reset clears the count and the command queue;
// element memory is not cleared.
`default_nettype none
module positional_insert_delete_list_unit #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF,
  parameter int QDEPTH = pidl_pkg::Q_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire pidl_pkg::in_t in_data,
  output logic               out_valid,
  output pidl_pkg::out_t     out_data
);
  import pidl_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  pidl_front u_front (
    .start    (start),
    .in_data  (in_data),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pidl_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  pidl_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
